FILE: hdl/b2b_pkg.sv
// ----------------------------------------------------------------------------
// BLAKE2b compression package
// Beat types, configuration register indexes, the initialization vector and
// the message schedule shared by the compression engine.
// ----------------------------------------------------------------------------
package b2b_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int CFG_W       = 7;

  localparam logic CFG_DIGEST_BYTES = 1'b0;
  localparam logic CFG_KEY_BYTES    = 1'b1;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [3:0]  word_index;
    logic        final_block;
    logic [7:0]  tail_bytes;
    logic        new_message;
  } in_t;

  typedef struct packed {
    logic [63:0] hash_word;
    logic        last_word;
  } out_t;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
      4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
      4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
    '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
      4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
    '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
      4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
    '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
      4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
    '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
      4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
    '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
      4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
    '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
      4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
    '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
      4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
    '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
      4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
  };

  function automatic logic [3:0] b2b_sigma(logic [3:0] rnd, logic [3:0] pos);
    logic [3:0] row;
    row = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
    return SIGMA[row][pos];
  endfunction

  function automatic logic [63:0] b2b_param(logic [CFG_W-1:0] dig,
                                            logic [CFG_W-1:0] key);
    return {32'h0, 8'h01, 8'h01, 1'b0, key, 1'b0, dig};
  endfunction

endpackage

FILE: hdl/blake2b_compression.sv
// ----------------------------------------------------------------------------
// BLAKE2b compression engine
// Buffers sixteen message words per block and runs the 12-round compression
// on one shared mixing unit; a final block returns the 8 digest words.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | in_data_i  (b2b_pkg::in_t)
// out     | output    | out_valid_o/ out_ready_i| out_data_o (b2b_pkg::out_t)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Words 0 to 14 of a block are taken one per cycle.
// Word 15 starts compression with in_ready_o low (counter update, setup,
// 384 mixing steps of the single adder unit, fold), then 8 beats out
// for a final block. Output beats wait on out_ready_i; no input is taken
// meanwhile. Reset loads the chaining value for a 64-byte unkeyed digest.
// ----------------------------------------------------------------------------
module blake2b_compression (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  b2b_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output b2b_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [b2b_pkg::CFG_W-1:0] cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COUNT = 6'b000010,
    S_SETUP = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [b2b_pkg::CFG_W-1:0] digest_q, key_q;
  logic [63:0] h_q [8];
  logic [63:0] h_d [8];
  logic [63:0] v_q [16];
  logic [63:0] v_d [16];
  logic [63:0] v_upd [16];
  logic [63:0] buf_q [16];
  logic [63:0] msg_q;
  logic [63:0] t0_q, t0_d, t1_q, t1_d;
  logic        carry_q, carry_d;
  logic        fin_q;
  logic [7:0]  tail_q;
  logic [1:0]  step_q, step_d;
  logic [2:0]  g_q, g_d;
  logic [3:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;

  logic        in_fire, out_fire;
  logic [63:0] op_a, op_b, op_m, sum, mixed, rot;
  logic [7:0]  add_n;
  logic [1:0]  row_amt [4];
  logic [1:0]  sel;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  assign out_data_o.hash_word = h_q[out_idx_q];
  assign out_data_o.last_word = (out_idx_q == 3'd7);

  assign op_a  = step_q[0] ? v_q[8]  : v_q[0];
  assign op_b  = step_q[0] ? v_q[12] : v_q[4];
  assign op_m  = step_q[0] ? 64'h0   : msg_q;
  assign sum   = op_a + op_b + op_m;
  assign mixed = (step_q[0] ? v_q[4] : v_q[12]) ^ sum;
  assign add_n = fin_q ? tail_q : 8'(b2b_pkg::BLOCK_BYTES);

  always_comb begin
    unique case (step_q)
      2'd0:    rot = {mixed[31:0], mixed[63:32]};
      2'd1:    rot = {mixed[23:0], mixed[63:24]};
      2'd2:    rot = {mixed[15:0], mixed[63:16]};
      default: rot = {mixed[62:0], mixed[63]};
    endcase
  end

  // The mixer always works on positions 0, 4, 8 and 12; the rows are turned
  // after each mix so that the next column or diagonal lands there.
  always_comb begin
    unique case (g_q)
      3'd3: begin
        row_amt[0] = 2'd1; row_amt[1] = 2'd2; row_amt[2] = 2'd3; row_amt[3] = 2'd0;
      end
      3'd7: begin
        row_amt[0] = 2'd1; row_amt[1] = 2'd0; row_amt[2] = 2'd3; row_amt[3] = 2'd2;
      end
      default: begin
        row_amt[0] = 2'd1; row_amt[1] = 2'd1; row_amt[2] = 2'd1; row_amt[3] = 2'd1;
      end
    endcase
  end

  always_comb begin
    v_upd = v_q;
    if (step_q[0]) begin
      v_upd[8] = sum;
      v_upd[4] = rot;
    end else begin
      v_upd[0]  = sum;
      v_upd[12] = rot;
    end
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    v_d       = v_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    carry_d   = carry_q;
    step_d    = step_q;
    g_d       = g_q;
    round_d   = round_q;
    out_idx_d = out_idx_q;
    sel       = 2'd0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.new_message) begin
            for (int i = 0; i < 8; i++) begin
              h_d[i] = b2b_pkg::IV[i];
            end
            h_d[0] = b2b_pkg::IV[0] ^ b2b_pkg::b2b_param(digest_q, key_q);
            t0_d   = 64'h0;
            t1_d   = 64'h0;
          end
          if (in_data_i.word_index == 4'd15) begin
            state_d = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        {carry_d, t0_d} = {1'b0, t0_q} + 65'(add_n);
        state_d = S_SETUP;
      end
      S_SETUP: begin
        t1_d = t1_q + 64'(carry_q);
        for (int i = 0; i < 8; i++) begin
          v_d[i]     = h_q[i];
          v_d[i + 8] = b2b_pkg::IV[i];
        end
        v_d[12] = b2b_pkg::IV[4] ^ t0_q;
        v_d[13] = b2b_pkg::IV[5] ^ t1_d;
        v_d[14] = b2b_pkg::IV[6] ^ {64{fin_q}};
        step_d  = 2'd0;
        g_d     = 3'd0;
        round_d = 4'd0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        v_d    = v_upd;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              sel = 2'(j) + row_amt[r];
              v_d[4 * r + j] = v_upd[4 * r + int'(sel)];
            end
          end
          g_d = g_q + 3'd1;
          if (g_q == 3'd7) begin
            round_d = round_q + 4'd1;
            if (round_q == 4'd11) begin
              state_d = S_FOLD;
            end
          end
        end
      end
      S_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] ^ v_q[i] ^ v_q[i + 8];
        end
        out_idx_d = 3'd0;
        state_d   = fin_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_fire) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      digest_q  <= b2b_pkg::CFG_W'(64);
      key_q     <= '0;
      for (int i = 1; i < 8; i++) begin
        h_q[i] <= b2b_pkg::IV[i];
      end
      h_q[0]    <= b2b_pkg::IV[0] ^ b2b_pkg::b2b_param(b2b_pkg::CFG_W'(64), '0);
      t0_q      <= '0;
      t1_q      <= '0;
      carry_q   <= 1'b0;
      fin_q     <= 1'b0;
      tail_q    <= '0;
      step_q    <= '0;
      g_q       <= '0;
      round_q   <= '0;
      out_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      h_q       <= h_d;
      t0_q      <= t0_d;
      t1_q      <= t1_d;
      carry_q   <= carry_d;
      step_q    <= step_d;
      g_q       <= g_d;
      round_q   <= round_d;
      out_idx_q <= out_idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          b2b_pkg::CFG_DIGEST_BYTES: digest_q <= cfg_data_i;
          b2b_pkg::CFG_KEY_BYTES:    key_q    <= cfg_data_i;
          default:                   digest_q <= digest_q;
        endcase
      end
      if (in_fire && in_data_i.word_index == 4'd15) begin
        fin_q  <= in_data_i.final_block;
        tail_q <= (in_data_i.tail_bytes > 8'(b2b_pkg::BLOCK_BYTES)) ?
                  8'(b2b_pkg::BLOCK_BYTES) : in_data_i.tail_bytes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    msg_q <= buf_q[b2b_pkg::b2b_sigma(round_d, {g_d, step_d[1]})];
    if (in_fire) begin
      buf_q[in_data_i.word_index] <= in_data_i.msg_word;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input and output beats offered together.");

  a_close_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.word_index == 4'd15) |=> (state_q == S_COUNT))
    else $error("Closing word did not start compression.");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.last_word) |=> in_ready_o)
    else $error("Engine not ready after the last digest beat.");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (round_q <= 4'd11))
    else $error("Round counter out of range.");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// BLAKE2b compression engine testbench
// Feeds message words over the input channel, with random bursts and gaps,
// and checks every digest beat against an in-bench BLAKE2b model. The model
// tracks the chaining value, the byte count and the block buffer. The run
// covers several digest and key length settings, a long output stall, and
// noise words and broken blocks next to well-formed messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int COMPRESS_CYCLES = 387;
  localparam int HOLD_CYCLES     = 600;

  localparam logic [63:0] H0 [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam int PERM [10][16] = '{
    '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
    '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
    '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
    '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
    '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
    '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
    '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
    '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
    '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
    '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
  };

  class b2b_digest_model;
    logic [b2b_pkg::CFG_W-1:0] digest_len;
    logic [b2b_pkg::CFG_W-1:0] key_len;
    logic [63:0]               chain [8];
    logic [63:0]               msg_buf [16];
    logic [127:0]              byte_count;
    logic [63:0]               work [16];
    b2b_pkg::out_t             digest_words [$];
    int                        fail_cnt;

    function new();
      digest_len = 7'd64;
      key_len    = 7'd0;
      fail_cnt   = 0;
      foreach (msg_buf[i]) msg_buf[i] = '0;
      start_message();
    endfunction

    function void set_reg(logic idx, logic [b2b_pkg::CFG_W-1:0] val);
      if (idx == b2b_pkg::CFG_DIGEST_BYTES) begin
        digest_len = val;
      end else begin
        key_len = val;
      end
    endfunction

    function void start_message();
      foreach (chain[i]) chain[i] = H0[i];
      chain[0] ^= 64'(digest_len) | (64'(key_len) << 8) | 64'h0000_0000_0101_0000;
      byte_count = '0;
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
      work[a] = work[a] + work[b] + x;
      work[d] = rotr(work[d] ^ work[a], 32);
      work[c] = work[c] + work[d];
      work[b] = rotr(work[b] ^ work[c], 24);
      work[a] = work[a] + work[b] + y;
      work[d] = rotr(work[d] ^ work[a], 16);
      work[c] = work[c] + work[d];
      work[b] = rotr(work[b] ^ work[c], 63);
    endfunction

    function void run_compress(logic [63:0] f0);
      int s;
      for (int i = 0; i < 8; i++) begin
        work[i]     = chain[i];
        work[i + 8] = H0[i];
      end
      work[12] ^= byte_count[63:0];
      work[13] ^= byte_count[127:64];
      work[14] ^= f0;
      for (int r = 0; r < 12; r++) begin
        s = r % 10;
        mix(0, 4,  8, 12, msg_buf[PERM[s][0]],  msg_buf[PERM[s][1]]);
        mix(1, 5,  9, 13, msg_buf[PERM[s][2]],  msg_buf[PERM[s][3]]);
        mix(2, 6, 10, 14, msg_buf[PERM[s][4]],  msg_buf[PERM[s][5]]);
        mix(3, 7, 11, 15, msg_buf[PERM[s][6]],  msg_buf[PERM[s][7]]);
        mix(0, 5, 10, 15, msg_buf[PERM[s][8]],  msg_buf[PERM[s][9]]);
        mix(1, 6, 11, 12, msg_buf[PERM[s][10]], msg_buf[PERM[s][11]]);
        mix(2, 7,  8, 13, msg_buf[PERM[s][12]], msg_buf[PERM[s][13]]);
        mix(3, 4,  9, 14, msg_buf[PERM[s][14]], msg_buf[PERM[s][15]]);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= work[i] ^ work[i + 8];
    endfunction

    function void note_word(b2b_pkg::in_t w);
      logic [7:0] tail;
      if (w.new_message) start_message();
      msg_buf[w.word_index] = w.msg_word;
      if (w.word_index != 4'd15) return;
      if (!w.final_block) begin
        byte_count += 128'(b2b_pkg::BLOCK_BYTES);
        run_compress(64'd0);
        return;
      end
      tail = (w.tail_bytes > 8'(b2b_pkg::BLOCK_BYTES)) ?
             8'(b2b_pkg::BLOCK_BYTES) : w.tail_bytes;
      byte_count += 128'(tail);
      run_compress(~64'd0);
      for (int i = 0; i < 8; i++) digest_words.push_back('{chain[i], i == 7});
    endfunction

    function void check_beat(b2b_pkg::out_t got);
      b2b_pkg::out_t want;
      if (digest_words.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected digest beat: hash %h last %b", got.hash_word, got.last_word);
        return;
      end
      want = digest_words.pop_front();
      if (got.hash_word !== want.hash_word || got.last_word !== want.last_word) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("digest beat mismatch: hash exp %h got %h, last exp %b got %b",
                   want.hash_word, got.hash_word, want.last_word, got.last_word);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  b2b_pkg::in_t              in_data;
  logic                      out_valid;
  logic                      out_ready;
  b2b_pkg::out_t             out_data;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [b2b_pkg::CFG_W-1:0] cfg_data;

  b2b_digest_model hasher = new();
  int  words_sent  = 0;
  int  burst_left  = 0;
  bit  hold_armed  = 1'b0;
  bit  hold        = 1'b0;

  blake2b_compression dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(input b2b_pkg::in_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    hasher.note_word(w);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_message(input int nblocks, input bit fresh);
    b2b_pkg::in_t w;
    for (int b = 0; b < nblocks; b++) begin
      for (int i = 0; i < 16; i++) begin
        w.msg_word    = {$urandom, $urandom};
        w.word_index  = 4'(i);
        w.new_message = fresh && b == 0 && i == 0;
        if (i == 15) begin
          w.final_block = (b == nblocks - 1);
          w.tail_bytes  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(129, 255))
                                                      : 8'($urandom_range(0, 128));
        end else begin
          w.final_block = ($urandom_range(0, 3) == 0);
          w.tail_bytes  = 8'($urandom);
        end
        send_word(w);
      end
    end
  endtask

  task automatic send_noise(input int n);
    b2b_pkg::in_t w;
    repeat (n) begin
      w.msg_word    = {$urandom, $urandom};
      w.word_index  = 4'($urandom);
      w.final_block = 1'($urandom);
      w.tail_bytes  = 8'($urandom);
      w.new_message = ($urandom_range(0, 3) == 0);
      send_word(w);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [b2b_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    hasher.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hasher.digest_words.size() != 0) @(posedge clk);
    repeat (COMPRESS_CYCLES + 16) @(posedge clk);
  endtask

  initial begin
    int  run_left;
    bit  stall;
    out_ready = 1'b0;
    run_left  = 0;
    stall     = 1'b1;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        stall    = !stall;
        run_left = stall ? $urandom_range(1, 6) : $urandom_range(1, 30);
      end
      run_left--;
      out_ready <= !stall && !hold;
    end
  end

  initial begin
    wait (hold_armed);
    do @(posedge clk); while (!out_valid);
    hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) hasher.check_beat(out_data);
  end

  initial begin
    logic [63:0]               msg;
    logic [b2b_pkg::CFG_W-1:0] dig_set [6];
    logic [b2b_pkg::CFG_W-1:0] key_set [6];
    int                        kind;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = b2b_pkg::CFG_DIGEST_BYTES;
    cfg_data = '0;
    dig_set  = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd20, 7'($urandom_range(1, 64))};
    key_set  = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd32, 7'($urandom_range(0, 64))};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 16; i++) begin
      case (i)
        0: msg = 64'd0;
        1: msg = 64'hFFFF_FFFF_FFFF_FFFF;
        2: msg = 64'h8000_0000_0000_0000;
        default: msg = {$urandom, $urandom};
      endcase
      send_word(b2b_pkg::in_t'{msg, 4'(i), i == 3, (i == 3) ? 8'hFF : 8'h00, 1'b0});
    end
    send_word(b2b_pkg::in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 8'hFF, 1'b0});
    send_word(b2b_pkg::in_t'{{$urandom, $urandom}, 4'd15, 1'b1, 8'd128, 1'b1});
    send_word(b2b_pkg::in_t'{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 8'd0, 1'b0});
    send_word(b2b_pkg::in_t'{64'd0, 4'd7, 1'b0, 8'd0, 1'b1});
    send_word(b2b_pkg::in_t'{64'd0, 4'd15, 1'b1, 8'd1, 1'b0});
    settle();

    for (int p = 0; p < 6; p++) begin
      write_reg(b2b_pkg::CFG_DIGEST_BYTES, dig_set[p]);
      write_reg(b2b_pkg::CFG_KEY_BYTES, key_set[p]);
      if (p == 2) hold_armed = 1'b1;
      while (words_sent < 21 + 44 * (p + 1)) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_message($urandom_range(1, 3), 1'b1);
        end else if (kind == 7) begin
          send_message($urandom_range(1, 2), 1'b0);
        end else begin
          send_noise($urandom_range(1, 5));
        end
      end
      settle();
    end

    if (hasher.fail_cnt == 0 && hasher.digest_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
